>>> rtl/tgra_pkg.sv
`timescale 1ns / 1ps

package tgra_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_FONT_MODE    = 2'd0;
    localparam logic [1:0] REG_HANZI_OFFSET = 2'd1;
    localparam logic [1:0] REG_ASCII16_BASE = 2'd2;
    localparam logic [1:0] REG_ASCII7_BASE  = 2'd3;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 24;

    localparam logic        FONT_RESET           = 1'b0;
    localparam logic [15:0] HANZI_OFFSET_RESET   = 16'd846;
    localparam logic [23:0] ASCII16_BASE_RESET   = 24'h03CF80;
    localparam logic [23:0] ASCII7_BASE_RESET    = 24'h03BFC0;

    // Glyph kinds
    localparam logic [1:0] KIND_16X16 = 2'd0;
    localparam logic [1:0] KIND_8X16  = 2'd1;
    localparam logic [1:0] KIND_5X7   = 2'd2;

    localparam logic [5:0] LEN_16X16 = 6'd32;
    localparam logic [5:0] LEN_8X16  = 6'd16;
    localparam logic [5:0] LEN_5X7   = 6'd8;

    localparam logic [7:0] ADV_16X16 = 8'd16;
    localparam logic [7:0] ADV_8X16  = 8'd8;
    localparam logic [7:0] ADV_5X7   = 8'd6;

    localparam logic [7:0] HANZI_FIRST = 8'hB0;
    localparam logic [7:0] HANZI_LAST  = 8'hF7;
    localparam logic [7:0] SYM_FIRST   = 8'hA1;
    localparam logic [7:0] SYM_LAST    = 8'hA3;
    localparam logic [7:0] TRAIL_FIRST = 8'hA1;
    localparam logic [7:0] PRINT_FIRST = 8'h20;
    localparam logic [7:0] PRINT_LAST  = 8'h7E;
    localparam logic [6:0] ROW_GLYPHS  = 7'd94;

    // Command queue depth
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
        logic [7:0] start_column;
        logic [2:0] start_page;
    } in_item_t;

    typedef struct packed {
        logic [23:0] rom_address;
        logic [5:0]  fetch_length;
        logic [1:0]  glyph_kind;
        logic [7:0]  glyph_column;
        logic [2:0]  glyph_page;
    } out_item_t;

    // Classified glyph passed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic       hanzi;     // 16x16 from the hanzi rows, else symbol rows
        logic [6:0] lead_off;  // lead minus first lead of its range
        logic [6:0] code_off;  // trail minus 0xA1, or ASCII minus 0x20
        logic [7:0] column;
        logic [2:0] page;
    } glyph_cmd_t;

    typedef struct packed {
        logic        font_mode;
        logic [15:0] hanzi_row_offset;
        logic [23:0] ascii16_base;
        logic [23:0] ascii7_base;
    } cfg_t;

endpackage

>>> rtl/tgra_front.sv
`timescale 1ns / 1ps

module tgra_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                font_mode,
    input  logic                in_valid,
    output logic                in_ready,
    input  tgra_pkg::in_item_t  in_data,
    input  logic                cmd_space,
    output logic                cmd_push,
    output tgra_pkg::glyph_cmd_t cmd
);
    import tgra_pkg::*;

    logic       lead_pending_reg, lead_pending_next;
    logic [7:0] held_lead_reg, held_lead_next;
    logic [7:0] column_reg, column_next;
    logic [2:0] page_reg, page_next;

    logic       accept;
    logic [7:0] b;
    logic [7:0] col_cur;
    logic [2:0] page_cur;
    logic       pend_cur;
    logic       printable;
    logic       is_lead;
    logic       emit;
    logic [7:0] adv;

    assign in_ready = cmd_space;
    assign accept   = in_valid && in_ready;
    assign b        = in_data.text_byte;

    always_comb
    begin
        col_cur   = in_data.first_byte ? in_data.start_column : column_reg;
        page_cur  = in_data.first_byte ? in_data.start_page : page_reg;
        pend_cur  = in_data.first_byte ? 1'b0 : lead_pending_reg;
        printable = (b >= PRINT_FIRST) && (b <= PRINT_LAST);
        is_lead   = ((b >= HANZI_FIRST) && (b <= HANZI_LAST)) ||
                    ((b >= SYM_FIRST) && (b <= SYM_LAST));

        emit              = 1'b0;
        adv               = '0;
        lead_pending_next = 1'b0;
        held_lead_next    = '0;
        cmd.kind          = KIND_8X16;
        cmd.hanzi         = held_lead_reg >= HANZI_FIRST;
        cmd.lead_off      = cmd.hanzi ? 7'(held_lead_reg - HANZI_FIRST)
                                      : 7'(held_lead_reg - SYM_FIRST);
        cmd.code_off      = 7'(b - PRINT_FIRST);
        cmd.column        = col_cur;
        cmd.page          = page_cur;

        if (b == '0)
        begin
            // end of string: drop any held lead, keep the cursor
        end
        else if (font_mode)
        begin
            if (printable)
            begin
                emit     = 1'b1;
                adv      = ADV_5X7;
                cmd.kind = KIND_5X7;
            end
        end
        else if (pend_cur && (b >= TRAIL_FIRST))
        begin
            emit         = 1'b1;
            adv          = ADV_16X16;
            cmd.kind     = KIND_16X16;
            cmd.code_off = 7'(b - TRAIL_FIRST);
        end
        else if (is_lead)
        begin
            lead_pending_next = 1'b1;
            held_lead_next    = b;
        end
        else if (printable)
        begin
            emit     = 1'b1;
            adv      = ADV_8X16;
            cmd.kind = KIND_8X16;
        end

        column_next = col_cur + adv;
        page_next   = page_cur;
        cmd_push    = accept && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            held_lead_reg    <= '0;
            column_reg       <= '0;
            page_reg         <= '0;
        end
        else if (accept)
        begin
            lead_pending_reg <= lead_pending_next;
            held_lead_reg    <= held_lead_next;
            column_reg       <= column_next;
            page_reg         <= page_next;
        end
    end

endmodule

>>> rtl/tgra_queue.sv
`timescale 1ns / 1ps

module tgra_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tgra_pkg::glyph_cmd_t push_data,
    output logic                 space,
    input  logic                 pop,
    output logic                 avail,
    output tgra_pkg::glyph_cmd_t head
);
    import tgra_pkg::*;

    glyph_cmd_t           slot_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0] count_reg, count_next;

    assign space = count_reg != QueueCntW'(QueueDepth);
    assign avail = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/tgra_back.sv
`timescale 1ns / 1ps

module tgra_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgra_pkg::cfg_t       cfg,
    input  logic                 cmd_avail,
    input  tgra_pkg::glyph_cmd_t cmd,
    output logic                 cmd_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tgra_pkg::out_item_t  out_data
);
    import tgra_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic [12:0] row_base;
    logic [16:0] glyph_index;

    assign cmd_pop = cmd_avail && (!out_valid_reg || out_ready);

    always_comb
    begin
        row_base    = 13'(cmd.lead_off) * 13'(ROW_GLYPHS);
        glyph_index = 17'(row_base) + 17'(cmd.code_off) +
                      (cmd.hanzi ? 17'(cfg.hanzi_row_offset) : 17'd0);

        out_data_next.fetch_length = LEN_8X16;
        out_data_next.rom_address  = cfg.ascii16_base + {13'd0, cmd.code_off, 4'd0};
        case (cmd.kind)
            KIND_16X16:
            begin
                out_data_next.fetch_length = LEN_16X16;
                out_data_next.rom_address  = {2'd0, glyph_index, 5'd0};
            end
            KIND_5X7:
            begin
                out_data_next.fetch_length = LEN_5X7;
                out_data_next.rom_address  = cfg.ascii7_base + {14'd0, cmd.code_off, 3'd0};
            end
            default:
            begin
            end
        endcase
        out_data_next.glyph_kind   = cmd.kind;
        out_data_next.glyph_column = cmd.column;
        out_data_next.glyph_page   = cmd.page;

        out_valid_next = out_valid_reg;
        if (cmd_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/text_glyph_rom_addresser_top.sv
`timescale 1ns / 1ps

// Turns a text byte stream into font ROM fetch requests, one beat per glyph:
// byte address, fetch length, glyph kind and the display column and page.
// Takes one text byte per cycle; the front classifies a glyph's last byte into
// a two-entry command queue and the back forms the address from the queue head
// into the output register, which presents the beat. A stalled output fills
// the queue and then holds in_ready low. Bytes that end a string, open
// a double-byte pair or are unprintable produce no beat. The configuration
// registers are to be written only while no bytes are in flight.
module text_glyph_rom_addresser_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tgra_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [tgra_pkg::CfgDataWidth-1:0]      cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  tgra_pkg::in_item_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output tgra_pkg::out_item_t                    out_data
);
    import tgra_pkg::*;

    cfg_t       cfg_reg;
    glyph_cmd_t front_cmd;
    glyph_cmd_t queue_head;
    logic       cmd_push;
    logic       cmd_space;
    logic       cmd_pop;
    logic       cmd_avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.font_mode        <= FONT_RESET;
            cfg_reg.hanzi_row_offset <= HANZI_OFFSET_RESET;
            cfg_reg.ascii16_base     <= ASCII16_BASE_RESET;
            cfg_reg.ascii7_base      <= ASCII7_BASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FONT_MODE:    cfg_reg.font_mode        <= cfg_data[0];
                REG_HANZI_OFFSET: cfg_reg.hanzi_row_offset <= cfg_data[15:0];
                REG_ASCII16_BASE: cfg_reg.ascii16_base     <= cfg_data;
                REG_ASCII7_BASE:  cfg_reg.ascii7_base      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tgra_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .font_mode (cfg_reg.font_mode),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_space (cmd_space),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    tgra_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .space     (cmd_space),
        .pop       (cmd_pop),
        .avail     (cmd_avail),
        .head      (queue_head)
    );

    tgra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_avail (cmd_avail),
        .cmd       (queue_head),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
